/* rtl/core/rsi_pkg.sv */
// Shared constants for the ray-sphere intersection pipeline.
// No dependencies; imported by the top level and the testbench.
`default_nettype none
package rsi_pkg;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIR_W   = 18;
  localparam int unsigned RAD_W   = 31;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned EPS_W   = 16;
  // discriminant is saturated to +(2^63-1)
  localparam int unsigned DISC_W  = 63;
  localparam logic [DISC_W-1:0] DISC_MAX = '1;
endpackage
`default_nettype wire

/* rtl/core/ray_sphere_intersection.sv */
// Ray-sphere intersection test, streaming, one ray/sphere item per cycle
// while the output is not stalled. Depends on rsi_pkg and rsi_sqrt.
//
// Each item carries a ray (origin, unit direction) and a sphere (center,
// radius); the block returns hit and the near-root distance in fixed point
// with FRAC_BITS fraction bits. The restoring square root resolves one
// root bit per stage. A new item is accepted every cycle, but the whole
// pipeline holds while a result waits at a stalled output. The epsilon
// register may be written at any time the pipeline is empty.
`default_nettype none
module ray_sphere_intersection #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [rsi_pkg::EPS_W-1:0]        cfg_hit_epsilon_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic signed [rsi_pkg::COORD_W-1:0] origin_x_i,
  input  wire logic signed [rsi_pkg::COORD_W-1:0] origin_y_i,
  input  wire logic signed [rsi_pkg::COORD_W-1:0] origin_z_i,
  input  wire logic signed [rsi_pkg::DIR_W-1:0]   dir_x_i,
  input  wire logic signed [rsi_pkg::DIR_W-1:0]   dir_y_i,
  input  wire logic signed [rsi_pkg::DIR_W-1:0]   dir_z_i,
  input  wire logic signed [rsi_pkg::COORD_W-1:0] center_x_i,
  input  wire logic signed [rsi_pkg::COORD_W-1:0] center_y_i,
  input  wire logic signed [rsi_pkg::COORD_W-1:0] center_z_i,
  input  wire logic [rsi_pkg::RAD_W-1:0]        sphere_radius_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  hit_o,
  output logic [rsi_pkg::DIST_W-1:0]            distance_o
);
  import rsi_pkg::*;

  localparam int unsigned D_W    = COORD_W + 1;
  localparam int unsigned P_W    = D_W + DIR_W;
  localparam int unsigned DOT_W  = P_W + 2;
  localparam int unsigned SQ_W   = 2 * D_W;
  localparam int unsigned RR_W   = 2 * RAD_W;
  localparam int unsigned C_W    = SQ_W + 2;
  localparam int unsigned HBM_W  = DOT_W - 1 - FRAC_BITS;
  localparam int unsigned HL_W   = (HBM_W + 1) / 2;
  localparam int unsigned HH_W   = HBM_W - HL_W;
  localparam int unsigned HSQ_W  = 2 * HBM_W;
  localparam int unsigned DF_W   = C_W + 2;
  localparam int unsigned RB     = (64 + FRAC_BITS) / 2;
  localparam int unsigned T_W    = ((HBM_W > RB) ? HBM_W : RB) + 2;
  localparam int unsigned SB_W   = HBM_W + 2;

  logic en;

  // configuration register, always ready
  logic [EPS_W-1:0] eps_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_W'(7);
    end else if (cfg_valid_i) begin
      eps_q <= cfg_hit_epsilon_i;
    end
  end

  // advance the pipeline unless a result waits at a stalled output
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // valid bits for the arithmetic stages
  logic [6:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[5:0], in_valid_i};
    end
  end

  // stage 1: offset from center
  logic signed [D_W-1:0]   d1_q [3];
  logic signed [DIR_W-1:0] dir1_q [3];
  logic [RAD_W-1:0]        r1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q[0]   <= D_W'(origin_x_i) - D_W'(center_x_i);
      d1_q[1]   <= D_W'(origin_y_i) - D_W'(center_y_i);
      d1_q[2]   <= D_W'(origin_z_i) - D_W'(center_z_i);
      dir1_q[0] <= dir_x_i;
      dir1_q[1] <= dir_y_i;
      dir1_q[2] <= dir_z_i;
      r1_q      <= sphere_radius_i;
    end
  end

  // stage 2: products
  logic signed [P_W-1:0] p2_q [3];
  logic [SQ_W-1:0]       sq2_q [3];
  logic [RR_W-1:0]       rr2_q;
  for (genvar i = 0; i < 3; i++) begin : g_mul
    logic [D_W-1:0] dm;
    assign dm = d1_q[i][D_W-1] ? D_W'(-d1_q[i]) : D_W'(d1_q[i]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        p2_q[i]  <= P_W'(d1_q[i]) * P_W'(dir1_q[i]);
        sq2_q[i] <= SQ_W'(dm) * SQ_W'(dm);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      rr2_q <= RR_W'(r1_q) * RR_W'(r1_q);
    end
  end

  // stage 3: dot products
  logic signed [DOT_W-1:0] dot3_q;
  logic [C_W-1:0]          dd3_q;
  logic [C_W-1:0]          rrq3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dot3_q <= DOT_W'(p2_q[0]) + DOT_W'(p2_q[1]) + DOT_W'(p2_q[2]);
      dd3_q  <= C_W'(sq2_q[0] >> FRAC_BITS) + C_W'(sq2_q[1] >> FRAC_BITS)
              + C_W'(sq2_q[2] >> FRAC_BITS);
      rrq3_q <= C_W'(rr2_q >> FRAC_BITS);
    end
  end

  // stage 4: half-b magnitude truncated toward zero, and c
  logic [DOT_W-1:0]    dotm;
  logic                hbn4_q;
  logic [HBM_W-1:0]    hbm4_q;
  logic signed [C_W-1:0] c4_q;
  assign dotm = dot3_q[DOT_W-1] ? DOT_W'(-dot3_q) : DOT_W'(dot3_q);
  always_ff @(posedge clk_i) begin
    if (en) begin
      hbn4_q <= dot3_q[DOT_W-1];
      hbm4_q <= HBM_W'(dotm >> FRAC_BITS);
      c4_q   <= $signed(dd3_q - rrq3_q);
    end
  end

  // stage 5: partial squares of the half-b magnitude
  logic [2*HH_W-1:0]    hh5_q;
  logic [HH_W+HL_W-1:0] hl5_q;
  logic [2*HL_W-1:0]    ll5_q;
  logic                 hbn5_q;
  logic [HBM_W-1:0]     hbm5_q;
  logic signed [C_W-1:0] c5_q;
  logic [HH_W-1:0] hbh;
  logic [HL_W-1:0] hbl;
  assign hbh = hbm4_q[HBM_W-1:HL_W];
  assign hbl = hbm4_q[HL_W-1:0];
  always_ff @(posedge clk_i) begin
    if (en) begin
      hh5_q  <= (2*HH_W)'(hbh) * (2*HH_W)'(hbh);
      hl5_q  <= (HH_W+HL_W)'(hbh) * (HH_W+HL_W)'(hbl);
      ll5_q  <= (2*HL_W)'(hbl) * (2*HL_W)'(hbl);
      hbn5_q <= hbn4_q;
      hbm5_q <= hbm4_q;
      c5_q   <= c4_q;
    end
  end

  // stage 6: combine the square
  logic [HSQ_W-1:0]     hsq6_q;
  logic                 hbn6_q;
  logic [HBM_W-1:0]     hbm6_q;
  logic signed [C_W-1:0] c6_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      hsq6_q <= (HSQ_W'(hh5_q) << (2*HL_W)) + (HSQ_W'(hl5_q) << (HL_W+1))
              + HSQ_W'(ll5_q);
      hbn6_q <= hbn5_q;
      hbm6_q <= hbm5_q;
      c6_q   <= c5_q;
    end
  end

  // stage 7: saturate hb^2, form the discriminant
  logic [127:0]            hsq_sh;
  logic [DISC_W-1:0]       hb2;
  logic signed [DF_W-1:0]  df;
  logic [DISC_W-1:0]       disc7_q;
  logic                    miss7_q;
  logic                    hbn7_q;
  logic [HBM_W-1:0]        hbm7_q;
  always_comb begin
    hsq_sh = 128'(hsq6_q) >> FRAC_BITS;
    hb2    = (|hsq_sh[127:DISC_W]) ? DISC_MAX : hsq_sh[DISC_W-1:0];
    df     = $signed(DF_W'(hb2)) - DF_W'(c6_q);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      miss7_q <= df[DF_W-1];
      disc7_q <= (|df[DF_W-1:DISC_W]) ? DISC_MAX : df[DISC_W-1:0];
      hbn7_q  <= hbn6_q;
      hbm7_q  <= hbm6_q;
    end
  end

  // square root of disc scaled up by the fraction bits
  logic            sq_v;
  logic [RB-1:0]   root;
  logic [SB_W-1:0] sb;
  rsi_sqrt #(
    .RB   (RB),
    .SB_W (SB_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[6]),
    .rad_i   ((2*RB)'(disc7_q) << FRAC_BITS),
    .sb_i    ({miss7_q, hbn7_q, hbm7_q}),
    .valid_o (sq_v),
    .root_o  (root),
    .sb_o    (sb)
  );

  // near root, epsilon test, clamp to the distance width
  logic                  f_miss, f_hbn;
  logic [HBM_W-1:0]      f_hbm;
  logic signed [T_W-1:0] t;
  logic                  hit_d;
  logic [DIST_W-1:0]     dist_d;
  always_comb begin
    {f_miss, f_hbn, f_hbm} = sb;
    t = f_hbn ? ($signed(T_W'(f_hbm)) - $signed(T_W'(root)))
              : (-$signed(T_W'(f_hbm)) - $signed(T_W'(root)));
    hit_d  = !f_miss && (t > $signed(T_W'(eps_q)));
    dist_d = '0;
    if (hit_d) begin
      dist_d = (|t[T_W-1:DIST_W]) ? '1 : t[DIST_W-1:0];
    end
  end

  logic              hit_q;
  logic [DIST_W-1:0] dist_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sq_v;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit_d;
      dist_q <= dist_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign distance_o  = dist_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !hit_q |-> dist_q == '0)
    else $error("miss with nonzero distance");
  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && hit_q |-> dist_q != '0)
    else $error("hit with zero distance");
  a_hit_beyond_eps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && hit_q |-> dist_q > DIST_W'(eps_q))
    else $error("hit not beyond epsilon");
endmodule
`default_nettype wire

/* rtl/core/rsi_sqrt.sv */
// Pipelined integer square root, one root bit per register stage.
// Generic over the root width; instantiated by the top level.
`default_nettype none
module rsi_sqrt #(
  parameter int unsigned RB   = 40,
  parameter int unsigned SB_W = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [2*RB-1:0] rad_i,
  input  wire logic [SB_W-1:0] sb_i,
  output logic                 valid_o,
  output logic [RB-1:0]        root_o,
  output logic [SB_W-1:0]      sb_o
);
  localparam int unsigned RW = 2 * RB;

  logic [RB+1:0]   rem_q  [RB];
  logic [RB-1:0]   root_q [RB];
  logic [RW-1:0]   rad_q  [RB];
  logic [SB_W-1:0] sb_q   [RB];
  logic [RB-1:0]   v_q;

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic [RB+1:0]   rem_in, rem_sh, trial, rem_d;
    logic [RB-1:0]   root_in, root_d;
    logic [RW-1:0]   rad_in;
    logic [SB_W-1:0] sb_in;
    logic            v_in, ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign sb_in   = sb_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign sb_in   = sb_q[k-1];
      assign v_in    = v_q[k-1];
    end

    // bring down the next bit pair and try the subtraction
    always_comb begin
      rem_sh = {rem_in[RB-1:0], rad_in[RW-1:RW-2]};
      trial  = {root_in, 2'b01};
      ge     = (rem_sh >= trial);
      rem_d  = ge ? (rem_sh - trial) : rem_sh;
      root_d = {root_in[RB-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= rad_in << 2;
        sb_q[k]   <= sb_in;
      end
    end
  end

  assign valid_o = v_q[RB-1];
  assign root_o  = root_q[RB-1];
  assign sb_o    = sb_q[RB-1];
endmodule
`default_nettype wire

/* tb/tb_ray_sphere_intersection.sv */
// Self-checking testbench for ray_sphere_intersection: streams ray/sphere items,
// predicts hit and distance in fixed point, and checks each result in order.
// Depends on rsi_pkg and the ray_sphere_intersection RTL.
`default_nettype none
module tb_ray_sphere_intersection;
  import rsi_pkg::*;

  localparam int FRAC = 16;
  localparam longint SATM = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [COORD_W-1:0] ox, oy, oz, cx, cy, cz;
    logic signed [DIR_W-1:0]   dx, dy, dz;
    logic [RAD_W-1:0]          rad;
  } ray_item_t;

  typedef struct {
    logic              hit;
    logic [DIST_W-1:0] distance;
  } hit_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [EPS_W-1:0] cfg_hit_epsilon_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [COORD_W-1:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [DIR_W-1:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic signed [COORD_W-1:0] center_x_i = '0, center_y_i = '0, center_z_i = '0;
  logic [RAD_W-1:0] sphere_radius_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  logic [DIST_W-1:0] distance_o;

  hit_result_t expected_hits[$];
  logic [EPS_W-1:0] eps_model = 16'd7;
  bit no_idle = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;

  ray_sphere_intersection #(.FRAC_BITS(FRAC)) dut (.*);

  always #5 clk_i = ~clk_i;

  // Clamp a wide signed value to +-(2^63-1)
  function automatic longint sat63(logic signed [127:0] v);
    if (v > 128'sd0 + SATM) return SATM;
    if (v < -(128'sd0 + SATM)) return -SATM;
    return longint'(v);
  endfunction

  // Product shifted right by FRAC, magnitude truncated, saturated
  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] am, bm, p;
    am = (a < 0) ? 128'(-a) : 128'(a);
    bm = (b < 0) ? 128'(-b) : 128'(b);
    p = (am * bm) >> FRAC;
    if (p > 128'(SATM)) p = 128'(SATM);
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  // floor(sqrt(v * 2^FRAC)) for nonnegative v
  function automatic longint fx_sqrt(longint v);
    logic [127:0] x, rem, root, trial;
    x = 128'(v) << FRAC;
    rem = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((x >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return longint'(root);
  endfunction

  function automatic hit_result_t intersect_ray(ray_item_t it, logic [EPS_W-1:0] eps);
    longint d[3], dv[3], dot2, hb, dd, r, c, disc, s, t;
    hit_result_t res;
    d[0] = longint'(it.ox) - longint'(it.cx);
    d[1] = longint'(it.oy) - longint'(it.cy);
    d[2] = longint'(it.oz) - longint'(it.cz);
    dv[0] = longint'(it.dx);
    dv[1] = longint'(it.dy);
    dv[2] = longint'(it.dz);
    dot2 = 0;
    dd = 0;
    for (int i = 0; i < 3; i++) begin
      dot2 += d[i] * dv[i];
      dd = sat63(128'sd0 + dd + fx_mul(d[i], d[i]));
    end
    // half-b, truncated toward zero
    hb = (dot2 < 0) ? -((-dot2) >>> FRAC) : (dot2 >>> FRAC);
    r = longint'({1'b0, it.rad});
    c = sat63(128'sd0 + dd - fx_mul(r, r));
    disc = sat63(128'sd0 + fx_mul(hb, hb) - c);
    res.hit = 1'b0;
    res.distance = '0;
    if (disc >= 0) begin
      s = fx_sqrt(disc);
      t = sat63(128'sd0 - hb - s);
      if (t > longint'({48'd0, eps})) begin
        res.hit = 1'b1;
        res.distance = (t > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
      end
    end
    return res;
  endfunction

  // Drive one item, hold until accepted, then predict its result
  task automatic send_ray(ray_item_t it);
    while (!no_idle && $urandom_range(99) < 25) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    origin_x_i = it.ox; origin_y_i = it.oy; origin_z_i = it.oz;
    dir_x_i = it.dx; dir_y_i = it.dy; dir_z_i = it.dz;
    center_x_i = it.cx; center_y_i = it.cy; center_z_i = it.cz;
    sphere_radius_i = it.rad;
    do @(posedge clk_i); while (in_stall_o);
    expected_hits.insert(expected_hits.size(), intersect_ray(it, eps_model));
  endtask

  // Wait for the pipeline to empty, then write the epsilon register
  task automatic write_epsilon(logic [EPS_W-1:0] v);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (expected_hits.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_hit_epsilon_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    eps_model = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic ray_item_t mk_ray(longint o, longint dxv, longint cc, longint r);
    ray_item_t it;
    it.ox = o[31:0]; it.oy = '0; it.oz = '0;
    it.dx = dxv[17:0]; it.dy = '0; it.dz = '0;
    it.cx = cc[31:0]; it.cy = '0; it.cz = '0;
    it.rad = r[30:0];
    return it;
  endfunction

  // Random unit direction, Q1.16
  task automatic rand_unit_dir(output logic signed [DIR_W-1:0] a, b, e);
    real x, y, z;
    x = real'($urandom_range(46000)) * ($urandom_range(1) ? -1.0 : 1.0);
    y = real'($urandom_range(46000)) * ($urandom_range(1) ? -1.0 : 1.0);
    z = $sqrt(65536.0 * 65536.0 - x * x - y * y);
    if ($urandom_range(1)) z = -z;
    a = 18'($rtoi(x)); b = 18'($rtoi(y)); e = 18'($rtoi(z));
  endtask

  function automatic ray_item_t wild_ray();
    ray_item_t it;
    it.ox = $urandom; it.oy = $urandom; it.oz = $urandom;
    it.cx = $urandom; it.cy = $urandom; it.cz = $urandom;
    it.dx = 18'($signed($urandom_range(131072)) - 65536);
    it.dy = 18'($signed($urandom_range(131072)) - 65536);
    it.dz = 18'($signed($urandom_range(131072)) - 65536);
    it.rad = 31'($urandom);
    return it;
  endfunction

  // Corner cases: field extremes, misses, inside hits, saturation
  task automatic test_corner_rays();
    ray_item_t it;
    longint big = 64'sh7FFF_FFFF;
    send_ray(mk_ray(0, 65536, 64'sd10 << 16, 64'sd2 << 16));      // plain hit
    send_ray(mk_ray(0, -65536, 64'sd10 << 16, 64'sd2 << 16));     // pointing away
    send_ray(mk_ray(0, 65536, 64'sd10 << 16, 64'sd1));            // tiny sphere
    send_ray(mk_ray(0, 65536, 0, 64'sd5 << 16));                  // origin inside
    send_ray(mk_ray(0, 65536, 64'sd10 << 16, 0));                 // zero radius
    send_ray(mk_ray(-big - 1, 65536, big, 0));                    // huge distance
    send_ray(mk_ray(-big - 1, 65536, big, big));                  // max radius
    send_ray(mk_ray(big, -65536, -big - 1, 64'sd1 << 16));
    send_ray(mk_ray(0, 65536, 64'sd3 << 16, 64'sd3 << 16));       // grazing origin
    send_ray(mk_ray(0, 65536, 7, 0));                             // t at epsilon
    send_ray(mk_ray(0, 65536, 8, 0));
    it.ox = 32'h8000_0000; it.oy = 32'h8000_0000; it.oz = 32'h8000_0000;
    it.cx = 32'h7FFF_FFFF; it.cy = 32'h7FFF_FFFF; it.cz = 32'h7FFF_FFFF;
    it.dx = 18'sd65536; it.dy = 18'sd65536; it.dz = 18'sd65536;
    it.rad = 31'h7FFF_FFFF;
    send_ray(it);                                                 // non-unit, saturating
    it.dx = -18'sd65536; it.dy = -18'sd65536; it.dz = -18'sd65536;
    send_ray(it);
    it.rad = '0;
    send_ray(it);
    it.ox = 32'h7FFF_FFFF; it.oy = 32'h7FFF_FFFF; it.oz = 32'h7FFF_FFFF;
    it.cx = 32'h8000_0000; it.cy = 32'h8000_0000; it.cz = 32'h8000_0000;
    send_ray(it);
    it = '{default: '0};
    send_ray(it);                                                 // all zero
  endtask

  // Rays aimed near a sphere center so hits and misses both occur
  task automatic test_aimed_rays(int count);
    ray_item_t it;
    longint k, o[3], dv[3];
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 15) begin
        send_ray(wild_ray());
        continue;
      end
      rand_unit_dir(it.dx, it.dy, it.dz);
      o[0] = $signed($urandom_range(1 << 25)) - (1 << 24);
      o[1] = $signed($urandom_range(1 << 25)) - (1 << 24);
      o[2] = $signed($urandom_range(1 << 25)) - (1 << 24);
      dv[0] = it.dx; dv[1] = it.dy; dv[2] = it.dz;
      k = $signed($urandom_range(1 << 23)) - (1 << 20);
      it.ox = 32'(o[0]); it.oy = 32'(o[1]); it.oz = 32'(o[2]);
      it.cx = 32'(o[0] + ((dv[0] * k) >>> 16) + $signed($urandom_range(1 << 15)) - (1 << 14));
      it.cy = 32'(o[1] + ((dv[1] * k) >>> 16) + $signed($urandom_range(1 << 15)) - (1 << 14));
      it.cz = 32'(o[2] + ((dv[2] * k) >>> 16) + $signed($urandom_range(1 << 15)) - (1 << 14));
      it.rad = 31'($urandom_range(1 << 20));
      send_ray(it);
    end
  endtask

  // Sweep epsilon across its range, extremes included
  task automatic test_epsilon_sweep();
    write_epsilon(16'd0);
    test_corner_rays();
    test_aimed_rays(60);
    write_epsilon(16'hFFFF);
    test_corner_rays();
    test_aimed_rays(60);
    write_epsilon(16'($urandom));
    test_aimed_rays(60);
    write_epsilon(16'd7);
  endtask

  // Back-to-back stream with no idling on either side
  task automatic test_full_rate();
    no_idle = 1'b1;
    test_aimed_rays(120);
    no_idle = 1'b0;
  endtask

  // Receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= no_idle ? 1'b0 : ($urandom_range(99) < 25);
  end

  // Compare each result against the oldest prediction
  always @(posedge clk_i) begin
    hit_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result hit=%0b distance=%h", $time, hit_o, distance_o);
        errors++;
      end else begin
        exp_r = expected_hits.pop_front();
        if (hit_o !== exp_r.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, hit_o);
          errors++;
        end
        if (distance_o !== exp_r.distance) begin
          $display("%0t: distance expected %h actual %h", $time, exp_r.distance,
                   distance_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_corner_rays();
    test_aimed_rays(100);
    test_full_rate();
    test_epsilon_sweep();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (expected_hits.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
rtl/core/rsi_pkg.sv
rtl/core/rsi_sqrt.sv
rtl/core/ray_sphere_intersection.sv
tb/tb_ray_sphere_intersection.sv
